// File: src/bsu_pkg.sv
// Shared types, register codes and field helpers for the BMP scanline unpacker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsu_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int MAX_WIDTH     = 8192;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QAW           = 2;
	localparam int PADDR_W       = 5;

	localparam logic [2:0] MODE_1BPP = 3'd0;
	localparam logic [2:0] MODE_4BPP = 3'd1;
	localparam logic [2:0] MODE_8BPP = 3'd2;
	localparam logic [2:0] MODE_16F  = 3'd3;
	localparam logic [2:0] MODE_24   = 3'd4;
	localparam logic [2:0] MODE_32F  = 3'd5;

	localparam logic [2:0] REG_PIXEL_MODE = 3'd0;
	localparam logic [2:0] REG_ROW_WIDTH  = 3'd1;
	localparam logic [2:0] REG_RED_MASK   = 3'd2;
	localparam logic [2:0] REG_GREEN_MASK = 3'd3;
	localparam logic [2:0] REG_BLUE_MASK  = 3'd4;
	localparam logic [2:0] REG_ALPHA_MASK = 3'd5;

	localparam logic CMD_PALETTE = 1'b0;
	localparam logic CMD_DATA    = 1'b1;

	localparam logic [31:0] OPAQUE = 32'hff000000;

	typedef enum logic [1:0] {
		KIND_PAL,
		KIND_F16,
		KIND_BGR,
		KIND_F32
	} pix_kind_t;

	typedef struct packed {
		logic [2:0]  pixel_mode;
		logic [13:0] row_width;
		logic [31:0] red_mask;
		logic [31:0] green_mask;
		logic [31:0] blue_mask;
		logic [31:0] alpha_mask;
	} cfg_regs_t;

	typedef struct packed {
		logic [4:0] shift;
		logic [3:0] bits;
	} field_info_t;

	typedef struct packed {
		field_info_t red;
		field_info_t green;
		field_info_t blue;
		field_info_t alpha;
	} field_set_t;

	// one queued command: palette write or data word with its pixel count
	typedef struct packed {
		logic        is_pal;
		logic [7:0]  pal_idx;
		logic [23:0] pal_color;
		logic [31:0] word;
		logic [15:0] carry;
		logic [1:0]  carry_cnt;
		logic [2:0]  mode;
		logic [5:0]  count;
		logic        row_end;
	} cmd_t;

	function automatic pix_kind_t kind_of(input logic [2:0] mode);
		pix_kind_t k;
		case (mode)
			MODE_1BPP, MODE_4BPP, MODE_8BPP: k = KIND_PAL;
			MODE_16F: k = KIND_F16;
			MODE_24:  k = KIND_BGR;
			default:  k = KIND_F32;
		endcase
		return k;
	endfunction

	// lowest set bit and width, capped to the top 8 bits of the mask
	function automatic field_info_t field_info(input logic [31:0] mask);
		logic [5:0] cnt;
		logic [5:0] sh;
		field_info_t fi;
		cnt = 6'($countones(mask));
		sh = '0;
		for (int i = 31; i >= 0; i--) begin
			if (mask[i]) sh = 6'(i);
		end
		if (cnt > 6'd8) begin
			sh = sh + cnt - 6'd8;
			cnt = 6'd8;
		end
		fi.shift = sh[4:0];
		fi.bits = cnt[3:0];
		return fi;
	endfunction

	function automatic logic [7:0] field_value(input logic [31:0] v, input logic [31:0] mask,
			input field_info_t fi);
		logic [31:0] t;
		logic [7:0] lim;
		t = (v & mask) >> fi.shift;
		lim = 8'((9'd1 << fi.bits) - 9'd1);
		return t[7:0] & lim;
	endfunction

	// 0xffff / (2^bits - 1)
	function automatic logic [16:0] field_scale(input logic [3:0] bits);
		logic [16:0] s;
		case (bits)
			4'd1: s = 17'd65535;
			4'd2: s = 17'd21845;
			4'd3: s = 17'd9362;
			4'd4: s = 17'd4369;
			4'd5: s = 17'd2114;
			4'd6: s = 17'd1040;
			4'd7: s = 17'd516;
			4'd8: s = 17'd257;
			default: s = 17'd0;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] field_scaled(input logic [7:0] x, input logic [3:0] bits);
		logic [24:0] p;
		p = {17'b0, x} * {8'b0, field_scale(bits)};
		return p[15:8];
	endfunction

endpackage

`default_nettype wire

// File: src/bsu_if.sv
// Stream channel interfaces: row words / palette writes in, ARGB pixels out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bsu_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  palette_index;
	logic [23:0] palette_color;
	logic [31:0] data_word;

	modport source(output valid, command, palette_index, palette_color, data_word,
		input ready);
	modport sink(input valid, command, palette_index, palette_color, data_word,
		output ready);
endinterface

interface bsu_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel;
	logic        row_end;
	logic        item_end;

	modport source(output valid, pixel, row_end, item_end, input ready);
	modport sink(input valid, pixel, row_end, item_end, output ready);
endinterface

`default_nettype wire

// File: src/bsu_cfg.sv
// APB register file for mode, row width and component masks; also registers
// the per-mask shift/width decode. Depends on bsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsu_cfg import bsu_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output cfg_regs_t               cfg,
	output field_set_t              fields
);

	cfg_regs_t  regs_q;
	field_set_t fields_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign cfg = regs_q;
	assign fields = fields_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.pixel_mode <= MODE_32F;
			regs_q.row_width <= 14'd1;
			regs_q.red_mask <= 32'h00ff0000;
			regs_q.green_mask <= 32'h0000ff00;
			regs_q.blue_mask <= 32'h000000ff;
			regs_q.alpha_mask <= 32'h0;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_PIXEL_MODE: regs_q.pixel_mode <= pwdata[2:0];
				REG_ROW_WIDTH:  regs_q.row_width <= pwdata[13:0];
				REG_RED_MASK:   regs_q.red_mask <= pwdata;
				REG_GREEN_MASK: regs_q.green_mask <= pwdata;
				REG_BLUE_MASK:  regs_q.blue_mask <= pwdata;
				REG_ALPHA_MASK: regs_q.alpha_mask <= pwdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fields_q <= '0;
		end else begin
			fields_q.red <= field_info(regs_q.red_mask);
			fields_q.green <= field_info(regs_q.green_mask);
			fields_q.blue <= field_info(regs_q.blue_mask);
			fields_q.alpha <= field_info(regs_q.alpha_mask);
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_PIXEL_MODE: prdata = {29'b0, regs_q.pixel_mode};
			REG_ROW_WIDTH:  prdata = {18'b0, regs_q.row_width};
			REG_RED_MASK:   prdata = regs_q.red_mask;
			REG_GREEN_MASK: prdata = regs_q.green_mask;
			REG_BLUE_MASK:  prdata = regs_q.blue_mask;
			REG_ALPHA_MASK: prdata = regs_q.alpha_mask;
			default:        prdata = 32'b0;
		endcase
	end

endmodule

`default_nettype wire

// File: src/bsu_front.sv
// Front end: accepts beats, tracks row position, pitch and 24 bpp carry, and
// queues palette writes and data words with their pixel counts. Depends on bsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsu_front import bsu_pkg::*; #(
	parameter int MAX_WIDTH = bsu_pkg::MAX_WIDTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	bsu_in_if.sink         word_ch,
	input  wire cfg_regs_t cfg,
	output logic           push,
	output cmd_t           push_data,
	input  wire logic      full
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PW = WW + 6;

	logic [WW-1:0] pix_done_q;
	logic [WW-1:0] words_done_q;
	logic [15:0]   carry_q;
	logic [1:0]    carry_cnt_q;

	logic          acc;
	logic [16:0]   rw_ext;
	logic [WW-1:0] width;
	logic [PW-1:0] wext;
	logic [PW-1:0] bits_total;
	logic [PW-1:0] pitch;
	logic [5:0]    slots;
	logic [PW-1:0] rem;
	logic [PW-1:0] n_p;
	logic [PW-1:0] done_p;
	logic          row_end;
	logic          wrap;
	logic [15:0]   carry_nx;
	logic [1:0]    carry_cnt_nx;

	assign word_ch.ready = !full;
	assign acc = word_ch.valid && word_ch.ready;

	always_comb begin
		rw_ext = 17'(cfg.row_width);
		if (rw_ext == 17'd0) rw_ext = 17'd1;
		if (rw_ext > 17'(MAX_WIDTH)) rw_ext = 17'(MAX_WIDTH);
		width = rw_ext[WW-1:0];
		wext = PW'(width);

		case (cfg.pixel_mode)
			MODE_1BPP: bits_total = wext;
			MODE_4BPP: bits_total = wext << 2;
			MODE_8BPP: bits_total = wext << 3;
			MODE_16F:  bits_total = wext << 4;
			MODE_24:   bits_total = (wext << 4) + (wext << 3);
			default:   bits_total = wext << 5;
		endcase
		pitch = (bits_total + PW'(31)) >> 5;

		case (cfg.pixel_mode)
			MODE_1BPP: slots = 6'd32;
			MODE_4BPP: slots = 6'd8;
			MODE_8BPP: slots = 6'd4;
			MODE_16F:  slots = 6'd2;
			MODE_24:   slots = (carry_cnt_q == 2'd2) ? 6'd2 : 6'd1;
			default:   slots = 6'd1;
		endcase

		rem = (pix_done_q < width) ? (wext - PW'(pix_done_q)) : '0;
		n_p = (PW'(slots) < rem) ? PW'(slots) : rem;
		done_p = PW'(pix_done_q) + n_p;
		row_end = (n_p != '0) && (done_p == wext);
		wrap = (PW'(words_done_q) + PW'(1)) >= pitch;

		carry_nx = carry_q;
		carry_cnt_nx = carry_cnt_q;
		if (cfg.pixel_mode == MODE_24) begin
			case (carry_cnt_q)
				2'd0: begin
					carry_nx = {8'b0, word_ch.data_word[31:24]};
					carry_cnt_nx = 2'd1;
				end
				2'd1: begin
					carry_nx = word_ch.data_word[31:16];
					carry_cnt_nx = 2'd2;
				end
				default: begin
					carry_nx = 16'b0;
					carry_cnt_nx = 2'd0;
				end
			endcase
		end
		if (done_p >= wext) begin
			carry_nx = 16'b0;
			carry_cnt_nx = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_done_q <= '0;
			words_done_q <= '0;
			carry_q <= '0;
			carry_cnt_q <= '0;
		end else if (acc && word_ch.command == CMD_DATA) begin
			if (wrap) begin
				pix_done_q <= '0;
				words_done_q <= '0;
				carry_q <= '0;
				carry_cnt_q <= '0;
			end else begin
				pix_done_q <= done_p[WW-1:0];
				words_done_q <= words_done_q + WW'(1);
				carry_q <= carry_nx;
				carry_cnt_q <= carry_cnt_nx;
			end
		end
	end

	// padding words give no result and are not queued
	assign push = acc && (word_ch.command == CMD_PALETTE || n_p != '0);

	always_comb begin
		push_data = '0;
		push_data.is_pal = (word_ch.command == CMD_PALETTE);
		push_data.pal_idx = word_ch.palette_index;
		push_data.pal_color = word_ch.palette_color;
		push_data.word = word_ch.data_word;
		push_data.carry = carry_q;
		push_data.carry_cnt = carry_cnt_q;
		push_data.mode = cfg.pixel_mode;
		push_data.count = n_p[5:0];
		push_data.row_end = row_end;
	end

endmodule

`default_nettype wire

// File: src/bsu_fifo.sv
// Short command queue between front and back end.
// Depends on bsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsu_fifo import bsu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	output logic      full,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty
);

	cmd_t           slot_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign full = (cnt_q == (QAW + 1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QAW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QAW + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (QAW + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/bsu_back.sv
// Back end: steps through the pixels of each queued word, looks up the palette,
// scales bitfields and drives the pixel channel. Depends on bsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsu_back import bsu_pkg::*; #(
	parameter int PALETTE_DEPTH = bsu_pkg::PALETTE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       head,
	input  wire logic       head_valid,
	output logic            pop,
	input  wire cfg_regs_t  cfg,
	input  wire field_set_t fields,
	bsu_out_if.source       pix_ch
);

	localparam int PAW = $clog2(PALETTE_DEPTH);

	logic [23:0]            pal_mem [PALETTE_DEPTH];
	logic [PALETTE_DEPTH-1:0] pal_vld_q;

	cmd_t       ent_q;
	logic       act_q;
	logic [4:0] k_q;

	logic       valid_s1;
	pix_kind_t  kind_s1;
	logic [7:0] idx_s1;
	logic [31:0] raw_s1;
	logic [23:0] bgr_s1;
	logic       row_end_s1;
	logic       item_end_s1;

	logic       valid_s2;
	pix_kind_t  kind_s2;
	logic [23:0] bgr_s2;
	logic [7:0] xr_s2;
	logic [7:0] xg_s2;
	logic [7:0] xb_s2;
	logic [7:0] xa_s2;
	logic [23:0] pal_rd_s2;
	logic       pal_hit_s2;
	logic       row_end_s2;
	logic       item_end_s2;

	logic       out_valid_q;
	logic [31:0] out_pixel_q;
	logic       out_row_end_q;
	logic       out_item_end_q;

	logic       adv;
	logic       last;
	logic       emit;
	logic       pal_we;
	logic [4:0] sh1;
	logic [4:0] sh4;
	logic [7:0] idx;
	logic [31:0] raw;
	logic [47:0] bytes48;
	logic [23:0] bgr;
	logic       opaque;
	logic [31:0] fpix;
	logic [31:0] pixel_nx;

	assign adv = !out_valid_q || pix_ch.ready;
	assign last = act_q && (ent_q.is_pal || ({1'b0, k_q} + 6'd1 == ent_q.count));
	assign pop = adv && head_valid && (!act_q || last);
	assign emit = adv && act_q && !ent_q.is_pal;
	assign pal_we = adv && act_q && ent_q.is_pal
		&& ({1'b0, ent_q.pal_idx} < 9'(PALETTE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			k_q <= '0;
		end else if (adv) begin
			if (pop) begin
				act_q <= 1'b1;
				k_q <= '0;
			end else if (last) begin
				act_q <= 1'b0;
			end else if (act_q) begin
				k_q <= k_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) ent_q <= head;
	end

	// slot select
	always_comb begin
		sh1 = {k_q[4:3], ~k_q[2:0]};
		sh4 = {k_q[2:1], ~k_q[0], 2'b00};
		case (ent_q.mode)
			MODE_1BPP: idx = {7'b0, ent_q.word[sh1]};
			MODE_4BPP: idx = {4'b0, ent_q.word[sh4 +: 4]};
			MODE_8BPP: idx = ent_q.word[{k_q[1:0], 3'b000} +: 8];
			default:   idx = 8'b0;
		endcase
		raw = (ent_q.mode == MODE_16F) ? {16'b0, ent_q.word[{k_q[0], 4'b0000} +: 16]}
			: ent_q.word;
		case (ent_q.carry_cnt)
			2'd0:    bytes48 = {16'b0, ent_q.word};
			2'd1:    bytes48 = {8'b0, ent_q.word, ent_q.carry[7:0]};
			default: bytes48 = {ent_q.word, ent_q.carry};
		endcase
		bgr = k_q[0] ? bytes48[47:24] : bytes48[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= emit;
			valid_s2 <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind_of(ent_q.mode);
			idx_s1 <= idx;
			raw_s1 <= raw;
			bgr_s1 <= bgr;
			row_end_s1 <= last && ent_q.row_end;
			item_end_s1 <= last;

			kind_s2 <= kind_s1;
			bgr_s2 <= bgr_s1;
			xr_s2 <= field_value(raw_s1, cfg.red_mask, fields.red);
			xg_s2 <= field_value(raw_s1, cfg.green_mask, fields.green);
			xb_s2 <= field_value(raw_s1, cfg.blue_mask, fields.blue);
			xa_s2 <= field_value(raw_s1, cfg.alpha_mask, fields.alpha);
			pal_hit_s2 <= ({1'b0, idx_s1} < 9'(PALETTE_DEPTH)) && pal_vld_q[idx_s1[PAW-1:0]];
			row_end_s2 <= row_end_s1;
			item_end_s2 <= item_end_s1;

			out_pixel_q <= pixel_nx;
			out_row_end_q <= row_end_s2;
			out_item_end_q <= item_end_s2;
		end
	end

	// palette storage
	always_ff @(posedge clk) begin
		if (pal_we) pal_mem[ent_q.pal_idx[PAW-1:0]] <= ent_q.pal_color;
	end

	always_ff @(posedge clk) begin
		if (adv) pal_rd_s2 <= pal_mem[idx_s1[PAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q <= '0;
		end else if (pal_we) begin
			pal_vld_q[ent_q.pal_idx[PAW-1:0]] <= 1'b1;
		end
	end

	always_comb begin
		opaque = (kind_s2 == KIND_F16) ? (cfg.alpha_mask[15:0] == 16'b0)
			: (cfg.alpha_mask == 32'b0);
		fpix = {field_scaled(xa_s2, fields.alpha.bits), field_scaled(xr_s2, fields.red.bits),
			field_scaled(xg_s2, fields.green.bits), field_scaled(xb_s2, fields.blue.bits)};
		if (opaque) fpix = fpix | OPAQUE;
		case (kind_s2)
			KIND_PAL: pixel_nx = OPAQUE | {8'b0, pal_hit_s2 ? pal_rd_s2 : 24'b0};
			KIND_BGR: pixel_nx = OPAQUE | {8'b0, bgr_s2};
			default:  pixel_nx = fpix;
		endcase
	end

	assign pix_ch.valid = out_valid_q;
	assign pix_ch.pixel = out_pixel_q;
	assign pix_ch.row_end = out_row_end_q;
	assign pix_ch.item_end = out_item_end_q;

endmodule

`default_nettype wire

// File: src/bmp_scanline_pixel_unpacker.sv
// BMP scanline unpacker: padded little-endian row words in, ARGB32 pixels out.
// Path: each queued word is held in the back-end entry register, and its pixels pass
// through stages s1 and s2 to the output register. Throughput: one pixel per cycle
// while pix_ch is ready; the back-end pixel sequencer steps a word's 1 to 32 pixels.
// Reset: async active low; clears control state, row counters, queue and palette valid bits.
// Depends on bsu_pkg, bsu_if, bsu_cfg, bsu_front, bsu_fifo, bsu_back.
`timescale 1ns / 1ps
`default_nettype none

module bmp_scanline_pixel_unpacker import bsu_pkg::*; #(
	parameter int PALETTE_DEPTH = bsu_pkg::PALETTE_DEPTH,
	parameter int MAX_WIDTH     = bsu_pkg::MAX_WIDTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	bsu_in_if.sink                  word_ch,
	bsu_out_if.source               pix_ch
);

	cfg_regs_t  cfg;
	field_set_t fields;
	logic       q_push;
	cmd_t       q_in;
	logic       q_full;
	logic       q_pop;
	cmd_t       q_head;
	logic       q_empty;

	bsu_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.fields  (fields)
	);

	bsu_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.word_ch   (word_ch),
		.cfg       (cfg),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full)
	);

	bsu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	bsu_back #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (!q_empty),
		.pop        (q_pop),
		.cfg        (cfg),
		.fields     (fields),
		.pix_ch     (pix_ch)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("queue pop while empty");

	a_row_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_ch.valid && pix_ch.row_end |-> pix_ch.item_end)
		else $error("row end not on last pixel of a word");

	a_full_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !word_ch.ready) else $error("input beat taken with queue full");

endmodule

`default_nettype wire

// File: sim/tb_bmp_scanline_pixel_unpacker.sv
// Testbench for bmp_scanline_pixel_unpacker: drives row words and palette writes, checks
// every ARGB pixel beat against an in-bench predictor of the unpacker.
// Depends on bsu_pkg, bsu_if and the unpacker RTL.
`timescale 1ns / 1ps

module tb_bmp_scanline_pixel_unpacker;
	import bsu_pkg::*;

	localparam int          CYCLE_LIMIT  = 1000000;
	localparam int          RANDOM_ITEMS = 180;
	localparam int          DRAIN_CYCLES = 12;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          HOLD_WORDS   = 12;
	localparam logic [2:0]  MODE_UNUSED  = 3'd7;

	typedef struct {
		logic        command;
		logic [7:0]  idx;
		logic [23:0] color;
		logic [31:0] word;
	} word_item_t;

	typedef struct {
		logic [31:0] pixel;
		logic        row_end;
		logic        item_end;
	} pixel_exp_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	bsu_in_if  word_ch ();
	bsu_out_if pix_ch ();

	bmp_scanline_pixel_unpacker u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.word_ch (word_ch),
		.pix_ch  (pix_ch)
	);

	// register mirror
	logic [2:0]  m_mode;
	logic [13:0] m_width;
	logic [31:0] m_red;
	logic [31:0] m_green;
	logic [31:0] m_blue;
	logic [31:0] m_alpha;

	// unpacker state mirror
	logic [23:0] pal_mirror [PALETTE_DEPTH];
	int unsigned px_count;
	int unsigned word_count;
	logic [15:0] carry_q;
	int unsigned carry_n;

	word_item_t  pending_words[$];
	pixel_exp_t  expected_pixels[$];

	bit          word_taken;
	bit          pix_taken;
	int          send_gap_max;
	int          recv_gap_max;
	int          gap_left;
	int          stall_left;
	int          hold_left;
	bit          hold_request;

	int          errors;
	int          cycle_count;
	int          beats_in;
	int          palette_beats;
	int          pixels_checked;
	int          settings_count;
	int          queued_items;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int unsigned eff_width();
		if (m_width == 14'd0)
			return 1;
		if (m_width > MAX_WIDTH)
			return MAX_WIDTH;
		return m_width;
	endfunction

	function automatic int unsigned bits_per_pixel();
		case (m_mode)
			MODE_1BPP: return 1;
			MODE_4BPP: return 4;
			MODE_8BPP: return 8;
			MODE_16F:  return 16;
			MODE_24:   return 24;
			default:   return 32;
		endcase
	endfunction

	function automatic int unsigned row_pitch();
		return (eff_width() * bits_per_pixel() + 31) / 32;
	endfunction

	function automatic logic [31:0] scale_component(logic [31:0] v, logic [31:0] mask);
		int unsigned sh;
		int unsigned nb;
		int unsigned lim;
		int unsigned x;
		int i;
		sh = 0;
		nb = 0;
		for (i = 0; i < 32; i++) begin
			if (mask[i]) begin
				if (nb == 0)
					sh = i;
				nb++;
			end
		end
		if (nb == 0)
			return 32'd0;
		if (nb > 8) begin
			sh = sh + nb - 8;
			nb = 8;
		end
		lim = (1 << nb) - 1;
		x = ((v & mask) >> sh) & lim;
		return (x * (32'hffff / lim)) >> 8;
	endfunction

	function automatic logic [31:0] argb_from_fields(logic [31:0] v, bit sixteen);
		logic [31:0] am;
		logic [31:0] p;
		am = sixteen ? {16'h0, m_alpha[15:0]} : m_alpha;
		p = (scale_component(v, m_red) << 16) | (scale_component(v, m_green) << 8)
			| scale_component(v, m_blue) | (scale_component(v, m_alpha) << 24);
		if (am == 32'd0)
			p = p | OPAQUE;
		return p;
	endfunction

	function automatic logic [31:0] palette_argb(logic [7:0] idx);
		return OPAQUE | {8'h00, pal_mirror[idx]};
	endfunction

	// expected pixel beats for one accepted input beat
	function automatic void unpack_word(logic cmd, logic [7:0] idx, logic [23:0] color,
			logic [31:0] w);
		int unsigned width;
		int unsigned pitch;
		int unsigned slots;
		int unsigned total;
		int unsigned left;
		int unsigned cc;
		int unsigned k;
		int unsigned i;
		int unsigned n;
		logic [7:0]  b [6];
		logic [31:0] p;
		pixel_exp_t  e;
		if (cmd == CMD_PALETTE) begin
			pal_mirror[idx] = color;
			return;
		end
		width = eff_width();
		pitch = row_pitch();
		n = 0;
		case (m_mode)
			MODE_1BPP: slots = 32;
			MODE_4BPP: slots = 8;
			MODE_8BPP: slots = 4;
			MODE_16F:  slots = 2;
			MODE_24: begin
				cc = (carry_n > 2) ? 2 : carry_n;
				for (i = 0; i < cc; i++)
					b[i] = carry_q[8*i +: 8];
				for (i = 0; i < 4; i++)
					b[cc + i] = w[8*i +: 8];
				total = cc + 4;
				slots = total / 3;
				left = total % 3;
				carry_q = '0;
				for (i = 0; i < left; i++)
					carry_q[8*i +: 8] = b[slots*3 + i];
				carry_n = left;
			end
			default:   slots = 1;
		endcase
		for (k = 0; k < slots && px_count < width; k++) begin
			case (m_mode)
				MODE_1BPP: p = palette_argb(8'((w >> ((k >> 3) * 8 + 7 - (k & 7))) & 32'h1));
				MODE_4BPP: p = palette_argb(8'((w >> ((k >> 1) * 8 + ((k & 1) ? 0 : 4)))
					& 32'hf));
				MODE_8BPP: p = palette_argb(8'((w >> (8 * k)) & 32'hff));
				MODE_16F:  p = argb_from_fields((w >> (16 * k)) & 32'hffff, 1'b1);
				MODE_24:   p = OPAQUE | {8'h00, b[3*k + 2], b[3*k + 1], b[3*k]};
				default:   p = argb_from_fields(w, 1'b0);
			endcase
			px_count++;
			e.pixel = p;
			e.row_end = (px_count == width);
			e.item_end = 1'b0;
			expected_pixels.push_back(e);
			n++;
		end
		if (n > 0) begin
			e = expected_pixels.pop_back();
			e.item_end = 1'b1;
			expected_pixels.push_back(e);
		end
		if (px_count >= width) begin
			carry_q = '0;
			carry_n = 0;
		end
		word_count++;
		if (word_count >= pitch) begin
			word_count = 0;
			px_count = 0;
			carry_q = '0;
			carry_n = 0;
		end
	endfunction

	function automatic void check_pixel(logic [31:0] px, logic re, logic ie);
		pixel_exp_t e;
		if (expected_pixels.size() == 0) begin
			$error("pixel beat with nothing expected: pixel %h", px);
			errors++;
			return;
		end
		e = expected_pixels.pop_front();
		pixels_checked++;
		if (px !== e.pixel) begin
			$error("pixel: expected %h, got %h", e.pixel, px);
			errors++;
		end
		if (re !== e.row_end) begin
			$error("row_end: expected %b, got %b", e.row_end, re);
			errors++;
		end
		if (ie !== e.item_end) begin
			$error("item_end: expected %b, got %b", e.item_end, ie);
			errors++;
		end
	endfunction

	// monitor: sample both channels at the rising edge
	always @(posedge clk) begin
		word_taken = arst_n && word_ch.valid && word_ch.ready;
		pix_taken = arst_n && pix_ch.valid && pix_ch.ready;
		if (word_taken) begin
			beats_in++;
			unpack_word(word_ch.command, word_ch.palette_index, word_ch.palette_color,
				word_ch.data_word);
		end
		if (pix_taken)
			check_pixel(pix_ch.pixel, pix_ch.row_end, pix_ch.item_end);
	end

	// word driver
	always @(negedge clk) begin
		word_item_t it;
		if (!arst_n) begin
			word_ch.valid <= 1'b0;
		end else if (word_ch.valid && !word_taken) begin
			// beat still offered
		end else if (gap_left > 0) begin
			word_ch.valid <= 1'b0;
			gap_left--;
		end else if (pending_words.size() > 0) begin
			it = pending_words.pop_front();
			word_ch.valid <= 1'b1;
			word_ch.command <= it.command;
			word_ch.palette_index <= it.idx;
			word_ch.palette_color <= it.color;
			word_ch.data_word <= it.word;
			gap_left = $urandom_range(0, send_gap_max);
		end else begin
			word_ch.valid <= 1'b0;
		end
	end

	// pixel receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			pix_ch.ready <= 1'b0;
		end else begin
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (pix_taken)
				stall_left = $urandom_range(0, recv_gap_max);
			if (hold_left > 0) begin
				hold_left--;
				pix_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pix_ch.ready <= 1'b0;
			end else begin
				pix_ch.ready <= 1'b1;
			end
		end
	end

	task automatic apb_write(logic [2:0] reg_id, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({reg_id, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (reg_id)
			REG_PIXEL_MODE: m_mode = value[2:0];
			REG_ROW_WIDTH:  m_width = value[13:0];
			REG_RED_MASK:   m_red = value;
			REG_GREEN_MASK: m_green = value;
			REG_BLUE_MASK:  m_blue = value;
			REG_ALPHA_MASK: m_alpha = value;
			default: ;
		endcase
	endtask

	task automatic wait_drain();
		while (pending_words.size() != 0 || word_ch.valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reconfigure(logic [2:0] mode, logic [13:0] width, logic [31:0] r,
			logic [31:0] g, logic [31:0] b, logic [31:0] a);
		wait_drain();
		apb_write(REG_PIXEL_MODE, {29'd0, mode});
		apb_write(REG_ROW_WIDTH, {18'd0, width});
		apb_write(REG_RED_MASK, r);
		apb_write(REG_GREEN_MASK, g);
		apb_write(REG_BLUE_MASK, b);
		apb_write(REG_ALPHA_MASK, a);
		settings_count++;
	endtask

	function automatic void push_palette(logic [7:0] i, logic [23:0] c);
		word_item_t it;
		it.command = CMD_PALETTE;
		it.idx = i;
		it.color = c;
		it.word = $urandom;
		pending_words.push_back(it);
		queued_items++;
		palette_beats++;
	endfunction

	function automatic void push_data(logic [31:0] w);
		word_item_t it;
		it.command = CMD_DATA;
		it.idx = 8'($urandom_range(0, 255));
		it.color = 24'($urandom);
		it.word = w;
		pending_words.push_back(it);
		queued_items++;
	endfunction

	function automatic logic [31:0] pick_mask();
		logic [63:0] run;
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hffffffff;
			2: begin
				run = ((64'd1 << $urandom_range(1, 12)) - 64'd1) << $urandom_range(0, 31);
				return run[31:0];
			end
			3: return $urandom;
			4: return 32'd1 << $urandom_range(0, 31);
			default: begin
				run = ((64'd1 << $urandom_range(1, 8)) - 64'd1) << $urandom_range(0, 15);
				return run[31:0];
			end
		endcase
	endfunction

	initial begin
		int unsigned pitch;
		int unsigned rows;
		int unsigned words;
		int          phase;
		int          directed_items;
		logic [2:0]  mode;
		logic [13:0] width;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		word_ch.valid = 1'b0;
		word_ch.command = CMD_DATA;
		word_ch.palette_index = '0;
		word_ch.palette_color = '0;
		word_ch.data_word = '0;
		pix_ch.ready = 1'b0;
		m_mode = MODE_32F;
		m_width = 14'd1;
		m_red = 32'h00ff0000;
		m_green = 32'h0000ff00;
		m_blue = 32'h000000ff;
		m_alpha = 32'h0;
		foreach (pal_mirror[i])
			pal_mirror[i] = '0;
		px_count = 0;
		word_count = 0;
		carry_q = '0;
		carry_n = 0;
		send_gap_max = 7;
		recv_gap_max = 7;
		gap_left = 0;
		stall_left = 0;
		hold_left = 0;
		hold_request = 1'b0;
		errors = 0;
		cycle_count = 0;
		beats_in = 0;
		palette_beats = 0;
		pixels_checked = 0;
		settings_count = 1;
		queued_items = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: 32 bpp fields, one pixel rows
		push_data(32'h00000000);
		push_data(32'hffffffff);
		push_palette(8'd0, 24'h0000ff);
		push_palette(8'd1, 24'hffffff);
		push_palette(8'd15, 24'h123456);
		push_palette(8'd255, 24'ha5c3e1);
		// 8 bpp, index 2 never written reads as zero
		reconfigure(MODE_8BPP, 14'd5, 32'h00ff0000, 32'h0000ff00, 32'h000000ff, 32'h0);
		push_data(32'h0fff0102);
		push_data(32'h000000ff);
		reconfigure(MODE_1BPP, 14'd40, 32'h00ff0000, 32'h0000ff00, 32'h000000ff, 32'h0);
		push_data(32'h8001ff00);
		push_data(32'hffffffff);
		reconfigure(MODE_4BPP, 14'd9, 32'h00ff0000, 32'h0000ff00, 32'h000000ff, 32'h0);
		push_data(32'h0f10f001);
		push_data(32'hffffffff);
		// 24 bpp with bytes straddling words
		reconfigure(MODE_24, 14'd5, 32'h00ff0000, 32'h0000ff00, 32'h000000ff, 32'h0);
		repeat (4) push_data($urandom);
		reconfigure(MODE_16F, 14'd3, 32'h0000f800, 32'h000007e0, 32'h0000001f, 32'h0);
		push_data(32'hffff0000);
		push_data(32'h00001234);
		// alpha mask outside the 16 bit pixel counts as opaque
		reconfigure(MODE_16F, 14'd2, 32'h00000f00, 32'h000000f0, 32'h0000000f, 32'hffff0000);
		push_data(32'h5a5af0f0);
		// wide mask keeps top 8 bits, zero mask gives zero
		reconfigure(MODE_32F, 14'd1, 32'h0000ffff, 32'h0, 32'h00000003, 32'hff000000);
		push_data(32'hffffffff);
		push_data(32'h80018003);
		// unknown mode and zero width
		reconfigure(MODE_UNUSED, 14'd0, 32'h00ff0000, 32'h0000ff00, 32'h000000ff, 32'h0);
		push_data(32'hc0ffee11);
		// receiver stalls long enough for the queue to fill and block the input
		hold_request = 1'b1;
		repeat (HOLD_WORDS) push_data($urandom);
		directed_items = queued_items;

		phase = 0;
		while (queued_items < directed_items + RANDOM_ITEMS) begin
			mode = 3'($urandom_range(0, 7));
			case ($urandom_range(0, 9))
				0: width = 14'd0;
				1: width = 14'($urandom_range(71, 300));
				default: width = 14'($urandom_range(1, 70));
			endcase
			reconfigure(mode, width, pick_mask(), pick_mask(), pick_mask(), pick_mask());
			send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
			recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
			pitch = row_pitch();
			words = (pitch > 60) ? 60 : pitch;
			rows = $urandom_range(1, (pitch > 15) ? 1 : 4);
			for (int r = 0; r < rows; r++) begin
				for (int k = 0; k < words; k++) begin
					if ($urandom_range(0, 5) == 0)
						push_palette(8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
							: $urandom_range(0, 15)), 24'($urandom));
					push_data($urandom);
				end
				if (phase == 1 && r == 0)
					wait_drain();
			end
			// partial row, carried over into the next setting
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) push_data($urandom);
			phase++;
		end

		// widest row: over-range width clamps to the maximum
		reconfigure(MODE_1BPP, 14'h3fff, 32'hffffffff, 32'h0, 32'h0000ffff, 32'h0);
		send_gap_max = 0;
		recv_gap_max = 3;
		repeat (MAX_WIDTH / 32) push_data($urandom);

		wait_drain();
		repeat (20) @(posedge clk);
		$display("Run covered %0d input beats (%0d palette writes) and %0d pixel beats",
			beats_in, palette_beats, pixels_checked);
		$display("over %0d register settings, including a maximum width row", settings_count);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
